[src/dmtet_pkg.sv]
// Shared types and constants for the direct-mapped tagged entry table.
package dmtet_pkg;

    // Field widths
    localparam int KEY_W       = 64;
    localparam int VALUE_W     = 16;
    localparam int COORD_W     = 8;
    localparam int OP_W        = 3;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_EXACT  = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_HEUR   = 3'd2;
    localparam logic [OP_W-1:0] OP_WR_FORCED = 3'd3;
    localparam logic [OP_W-1:0] OP_WR_BOOK   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_HEUR       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVALID_COORD = 8'd1;

    // Reset values
    localparam logic signed [VALUE_W-1:0] RST_NO_HEUR       = 16'sh7FFF;
    localparam logic signed [COORD_W-1:0] RST_INVALID_COORD = -8'sd1;
    localparam logic signed [VALUE_W-1:0] EXACT_NONE        = -16'sd1;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] exact;
        logic signed [VALUE_W-1:0] heur;
        logic signed [COORD_W-1:0] forced_x;
        logic signed [COORD_W-1:0] forced_y;
        logic signed [COORD_W-1:0] book_x;
        logic signed [COORD_W-1:0] book_y;
    } entry_t;

    // One result transaction
    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] exact_value;
        logic signed [VALUE_W-1:0] heur_value;
        logic signed [COORD_W-1:0] forced_x;
        logic signed [COORD_W-1:0] forced_y;
        logic signed [COORD_W-1:0] book_x;
        logic signed [COORD_W-1:0] book_y;
    } result_t;

    // Write-back request from the update logic
    typedef struct packed {
        logic   req;
        entry_t data;
    } wr_ctl_t;

    // Reset sequencer states
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

endpackage

[src/direct_mapped_tagged_entry_table_core.sv]
// Top level: direct-mapped tagged entry table with read-modify-write pipeline.
// Throughput: one transaction per cycle when the result stream is not stalled; each
// one reads the entry memory once, write ops write it back, and a one-entry forwarding
// register covers back-to-back accesses to the same index. After reset a clearing pass
// writes all 2^INDEX_BITS entries with s_tready low; configuration writes are taken throughout.
module direct_mapped_tagged_entry_table_core #(
    parameter int INDEX_BITS = 10
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // Input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [dmtet_pkg::IN_TDATA_W-1:0]        s_tdata,  // hash, value, move_x, move_y
    input  logic [dmtet_pkg::OP_W-1:0]              s_tuser,  // op
    // Result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [dmtet_pkg::OUT_TDATA_W-1:0]       m_tdata,  // exact_value, heur_value,
                                                              // forced_x, forced_y,
                                                              // book_x, book_y
    output logic [0:0]                              m_tuser,  // hit
    // Configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [dmtet_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [dmtet_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int KW = dmtet_pkg::KEY_W;
    localparam int VW = dmtet_pkg::VALUE_W;
    localparam int CW = dmtet_pkg::COORD_W;

    // Configuration registers
    logic signed [VW-1:0] no_heur_reg;
    logic signed [CW-1:0] inv_coord_reg;

    // Reset clearing sequencer
    dmtet_pkg::state_t     state_reg, state_next;
    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic                  clearing;

    // Stage 1: transaction waiting on memory read data
    logic                   s1_valid_reg;
    logic [dmtet_pkg::OP_W-1:0] s1_op_reg;
    logic [KW-1:0]          s1_hash_reg;
    logic signed [VW-1:0]   s1_value_reg;
    logic signed [CW-1:0]   s1_mx_reg;
    logic signed [CW-1:0]   s1_my_reg;
    logic                   s1_fire;
    logic [INDEX_BITS-1:0]  s1_idx;

    // Forwarding of the most recent write
    logic                   fwd_valid_reg;
    logic [INDEX_BITS-1:0]  fwd_idx_reg;
    dmtet_pkg::entry_t      fwd_entry_reg;

    // Output register
    logic                   out_valid_reg;
    dmtet_pkg::result_t     out_data_reg;

    // Memory and update wiring
    logic                   in_fire;
    dmtet_pkg::entry_t      rd_data;
    dmtet_pkg::entry_t      stored;
    dmtet_pkg::result_t     result;
    dmtet_pkg::wr_ctl_t     wr;
    logic                   ram_we;
    logic [INDEX_BITS-1:0]  ram_waddr;
    dmtet_pkg::entry_t      ram_wdata;
    dmtet_pkg::entry_t      rst_entry;

    // Configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            no_heur_reg   <= dmtet_pkg::RST_NO_HEUR;
            inv_coord_reg <= dmtet_pkg::RST_INVALID_COORD;
        end else if (cfg_valid && cfg_ready) begin
            priority if (cfg_index == dmtet_pkg::CFG_NO_HEUR) begin
                no_heur_reg <= cfg_data;
            end else if (cfg_index == dmtet_pkg::CFG_INVALID_COORD) begin
                inv_coord_reg <= cfg_data[CW-1:0];
            end else begin
                no_heur_reg <= no_heur_reg;
            end
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dmtet_pkg::ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = dmtet_pkg::ST_RUN;
                end
            end
            dmtet_pkg::ST_RUN: begin
                state_next = dmtet_pkg::ST_RUN;
            end
            default: begin
                state_next = dmtet_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        unique case (state_reg)
            dmtet_pkg::ST_CLEAR: clearing = 1'b1;
            dmtet_pkg::ST_RUN:   clearing = 1'b0;
            default:             clearing = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dmtet_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clearing) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Handshakes
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing && (!s1_valid_reg || s1_fire);
    assign in_fire  = s_tvalid && s_tready;

    // Entry memory
    always_comb begin
        rst_entry          = '0;
        rst_entry.exact    = dmtet_pkg::EXACT_NONE;
        rst_entry.heur     = dmtet_pkg::RST_NO_HEUR;
        rst_entry.forced_x = dmtet_pkg::RST_INVALID_COORD;
        rst_entry.forced_y = dmtet_pkg::RST_INVALID_COORD;
        rst_entry.book_x   = dmtet_pkg::RST_INVALID_COORD;
        rst_entry.book_y   = dmtet_pkg::RST_INVALID_COORD;
    end

    assign s1_idx    = s1_hash_reg[INDEX_BITS-1:0];
    assign ram_we    = clearing || (s1_fire && wr.req);
    assign ram_waddr = clearing ? clr_addr_reg : s1_idx;
    assign ram_wdata = clearing ? rst_entry : wr.data;

    dmtet_ram #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (in_fire),
        .rd_addr (s_tdata[INDEX_BITS-1:0]),
        .rd_data (rd_data),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata)
    );

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_op_reg    <= s_tuser;
            s1_hash_reg  <= s_tdata[KW-1:0];
            s1_value_reg <= s_tdata[KW+VW-1:KW];
            s1_mx_reg    <= s_tdata[KW+VW+CW-1:KW+VW];
            s1_my_reg    <= s_tdata[KW+VW+2*CW-1:KW+VW+CW];
        end
    end

    // Newest contents of the entry: forwarded write or memory read
    assign stored = (fwd_valid_reg && (fwd_idx_reg == s1_idx)) ? fwd_entry_reg : rd_data;

    dmtet_rmw u_rmw (
        .stored    (stored),
        .op        (s1_op_reg),
        .hash      (s1_hash_reg),
        .value     (s1_value_reg),
        .move_x    (s1_mx_reg),
        .move_y    (s1_my_reg),
        .no_heur   (no_heur_reg),
        .inv_coord (inv_coord_reg),
        .result    (result),
        .wr        (wr)
    );

    // Forwarding register tracks the last write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s1_fire && wr.req) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && wr.req) begin
            fwd_idx_reg   <= s1_idx;
            fwd_entry_reg <= wr.data;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.hit;
    assign m_tdata  = {out_data_reg.book_y, out_data_reg.book_x,
                       out_data_reg.forced_y, out_data_reg.forced_x,
                       out_data_reg.heur_value, out_data_reg.exact_value};

    // No transaction enters while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |-> (state_reg == dmtet_pkg::ST_RUN))
        else $error("input accepted during clearing pass");

    // Outside the clearing pass only a retiring transaction writes memory
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && !clearing) |-> s1_fire)
        else $error("memory written without a retiring transaction");

    // A stalled stage 1 transaction stays in place
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_hash_reg)))
        else $error("stage 1 transaction lost while stalled");

    // A miss always presents the exact-value sentinel
    a_miss_sentinel: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire |=> (m_tuser[0] || (m_tdata[VW-1:0] == dmtet_pkg::EXACT_NONE)))
        else $error("miss without exact-value sentinel");

endmodule

[src/dmtet_ram.sv]
// Entry memory: one write port, one read port with registered read data.
module dmtet_ram #(
    parameter int INDEX_BITS = 10
) (
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [INDEX_BITS-1:0]  rd_addr,
    output dmtet_pkg::entry_t      rd_data,
    input  logic                   wr_en,
    input  logic [INDEX_BITS-1:0]  wr_addr,
    input  dmtet_pkg::entry_t      wr_data
);

    localparam int DEPTH = 1 << INDEX_BITS;

    dmtet_pkg::entry_t mem [DEPTH];
    dmtet_pkg::entry_t rd_data_reg;

    // Read returns the old contents when the same entry is written in that cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/dmtet_rmw.sv]
// Key compare, result select and entry update for one transaction.
module dmtet_rmw (
    input  dmtet_pkg::entry_t                             stored,
    input  logic [dmtet_pkg::OP_W-1:0]                    op,
    input  logic [dmtet_pkg::KEY_W-1:0]                   hash,
    input  logic signed [dmtet_pkg::VALUE_W-1:0]          value,
    input  logic signed [dmtet_pkg::COORD_W-1:0]          move_x,
    input  logic signed [dmtet_pkg::COORD_W-1:0]          move_y,
    input  logic signed [dmtet_pkg::VALUE_W-1:0]          no_heur,
    input  logic signed [dmtet_pkg::COORD_W-1:0]          inv_coord,
    output dmtet_pkg::result_t                            result,
    output dmtet_pkg::wr_ctl_t                            wr
);

    logic              hit;
    logic              clears;
    dmtet_pkg::entry_t base;

    assign hit = (stored.key == hash);

    // Lookup result: stored fields on a hit, sentinels on a miss
    always_comb begin
        result.hit         = hit;
        result.exact_value = hit ? stored.exact    : dmtet_pkg::EXACT_NONE;
        result.heur_value  = hit ? stored.heur     : no_heur;
        result.forced_x    = hit ? stored.forced_x : inv_coord;
        result.forced_y    = hit ? stored.forced_y : inv_coord;
        result.book_x      = hit ? stored.book_x   : inv_coord;
        result.book_y      = hit ? stored.book_y   : inv_coord;
    end

    // Value and forced-move writes wipe a foreign entry; book writes do not
    assign clears = (op == dmtet_pkg::OP_WR_EXACT) || (op == dmtet_pkg::OP_WR_HEUR)
                 || (op == dmtet_pkg::OP_WR_FORCED);

    always_comb begin
        base = stored;
        if (clears && !hit) begin
            base.exact    = dmtet_pkg::EXACT_NONE;
            base.heur     = no_heur;
            base.forced_x = inv_coord;
            base.forced_y = inv_coord;
            base.book_x   = inv_coord;
            base.book_y   = inv_coord;
        end
        wr.data     = base;
        wr.data.key = hash;
        wr.req      = 1'b1;
        unique case (op)
            dmtet_pkg::OP_WR_EXACT: begin
                wr.data.exact = value;
            end
            dmtet_pkg::OP_WR_HEUR: begin
                wr.data.heur = value;
            end
            dmtet_pkg::OP_WR_FORCED: begin
                wr.data.forced_x = move_x;
                wr.data.forced_y = move_y;
            end
            dmtet_pkg::OP_WR_BOOK: begin
                wr.data.book_x = move_x;
                wr.data.book_y = move_y;
            end
            default: begin
                wr.req = 1'b0;
            end
        endcase
    end

endmodule
